FILE: design/assert_macros.svh
// Assertion macros for the transcoder modules; only cp1251u8_back uses them.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define CP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds out of reset
`define CP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/cp1251u8_pkg.sv
// Shared types, constants and helpers of the cp1251 / UTF-8 transcoder.
// No dependencies; used by the front, queue, back and top-level files.
package cp1251u8_pkg;

  // Register byte addresses
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_DIRECTION = 1'b0;

  // Direction codes
  localparam logic DIR_TO_UTF8  = 1'b0;
  localparam logic DIR_TO_CP1251 = 1'b1;

  localparam logic [7:0]  QMARK       = 8'h3F;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] CYR_FIRST   = 16'h0410;
  localparam logic [15:0] CYR_LAST    = 16'h044F;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  // Code points of cp1251 bytes 0x80..0xBF
  localparam logic [15:0] HIGH_MAP [64] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  // Work kinds carried through the queue
  typedef enum logic {
    JOB_FWD,
    JOB_REV
  } job_kind_t;

  // One queued job: ready-made UTF-8 bytes, or UTF-8 bytes still to parse
  typedef struct packed {
    job_kind_t        kind;
    logic [3:0][7:0]  bytes;
    logic [2:0]       cnt;
  } job_t;

  // Length of the UTF-8 sequence a lead byte opens (1 for anything else)
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd1;
    if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

FILE: design/cp1251_utf8_transcoder.sv
// Top level of the cp1251 / UTF-8 transcoder: config register and part wiring.
// Depends on cp1251u8_pkg, cp1251u8_front, cp1251u8_queue and cp1251u8_back.
//
//   channel  | ports                                   | beat moves
//   ---------+-----------------------------------------+---------------------------
//   input    | in_valid/in_ready, in_byte, in_final_byte | one source byte
//   result   | out_valid/out_ready, out_byte, out_run_end | one converted byte
//   config   | cfg_psel/penable/pwrite/paddr/pwdata     | direction register write
//
// An input beat yields 0 to 3 result beats, sent one per cycle while out_ready is high
// through the single-byte output register of the back part. A two-job queue decouples
// the two parts, so in_ready drops only when it is full. Reset is synchronous and
// clears direction, the pending sequence and all valid flags; no clearing pass follows.
// out_ready low holds the result register; the input side keeps going until the
// queue fills.
module cp1251_utf8_transcoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              in_final_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_run_end,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cp1251u8_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  logic               direction_r, direction_nxt;
  logic               cfg_wr;
  logic               q_full, push, pop, head_valid;
  cp1251u8_pkg::job_t push_job, head_job;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    direction_nxt = direction_r;
    if (cfg_wr && cfg_paddr[2] == cp1251u8_pkg::REG_DIRECTION) begin
      direction_nxt = cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == cp1251u8_pkg::REG_DIRECTION) ?
                      {31'd0, direction_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= cp1251u8_pkg::DIR_TO_UTF8;
    end else begin
      direction_r <= direction_nxt;
    end
  end

  cp1251u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .direction     (direction_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  cp1251u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  cp1251u8_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (head_valid),
    .q_job       (head_job),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

endmodule

FILE: design/cp1251u8_queue.sv
// Two-entry job queue between the front and back parts of the transcoder.
// Depends on cp1251u8_pkg for the job type.
module cp1251u8_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cp1251u8_pkg::job_t  push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output cp1251u8_pkg::job_t  head_job
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cp1251u8_pkg::job_t ent_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: design/cp1251u8_front.sv
// Front part: takes input beats, maps cp1251 bytes or gathers UTF-8 sequences.
// Depends on cp1251u8_pkg; feeds jobs to cp1251u8_queue.
module cp1251u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                direction,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_final_byte,
  input  logic                q_full,
  output logic                push,
  output cp1251u8_pkg::job_t  job
);

  logic [7:0]  pend_r [3];
  logic [7:0]  pend_nxt [3];
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [2:0]  slen_r, slen_nxt;
  logic        acc;
  logic [15:0] cp;
  logic [2:0]  lead;
  logic [2:0]  cnt_inc;
  cp1251u8_pkg::job_t fwd_job, rev_job;

  // Code point of a cp1251 byte
  function automatic logic [15:0] cp_of_byte(input logic [7:0] b);
    logic [15:0] r;
    if (!b[7]) begin
      r = {8'h00, b};
    end else if (b[6]) begin
      r = cp1251u8_pkg::CYR_FIRST + {10'd0, b[5:0]};
    end else begin
      r = cp1251u8_pkg::HIGH_MAP[b[5:0]];
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign cp       = cp_of_byte(in_byte);
  assign lead     = cp1251u8_pkg::lead_len(in_byte);
  assign cnt_inc  = {1'b0, pcnt_r} + 3'd1;

  // Encode the code point as UTF-8
  always_comb begin
    fwd_job.kind  = cp1251u8_pkg::JOB_FWD;
    fwd_job.bytes = '0;
    if (cp < 16'h0080) begin
      fwd_job.bytes[0] = cp[7:0];
      fwd_job.cnt      = 3'd1;
    end else if (cp < cp1251u8_pkg::TWO_BYTE_LIMIT) begin
      fwd_job.bytes[0] = {3'b110, cp[10:6]};
      fwd_job.bytes[1] = {2'b10, cp[5:0]};
      fwd_job.cnt      = 3'd2;
    end else begin
      fwd_job.bytes[0] = {4'b1110, cp[15:12]};
      fwd_job.bytes[1] = {2'b10, cp[11:6]};
      fwd_job.bytes[2] = {2'b10, cp[5:0]};
      fwd_job.cnt      = 3'd3;
    end
  end

  // Gather pending bytes and the new byte into one buffer to parse
  always_comb begin
    rev_job.kind     = cp1251u8_pkg::JOB_REV;
    rev_job.bytes[0] = (pcnt_r > 2'd0) ? pend_r[0] : in_byte;
    rev_job.bytes[1] = (pcnt_r > 2'd1) ? pend_r[1] : in_byte;
    rev_job.bytes[2] = (pcnt_r > 2'd2) ? pend_r[2] : in_byte;
    rev_job.bytes[3] = in_byte;
    rev_job.cnt      = cnt_inc;
  end

  // Classify the accepted beat and update the pending sequence
  always_comb begin
    push     = 1'b0;
    job      = fwd_job;
    pcnt_nxt = pcnt_r;
    slen_nxt = slen_r;
    for (int j = 0; j < 3; j++) begin
      pend_nxt[j] = pend_r[j];
    end
    if (acc) begin
      if (direction == cp1251u8_pkg::DIR_TO_UTF8) begin
        // drop NUL and the undefined byte
        push     = (cp != 16'h0000);
        pcnt_nxt = 2'd0;
        slen_nxt = 3'd0;
      end else if (in_final_byte || (pcnt_r != 2'd0 && !(cnt_inc < slen_r))) begin
        push     = 1'b1;
        job      = rev_job;
        pcnt_nxt = 2'd0;
        slen_nxt = 3'd0;
      end else if (pcnt_r == 2'd0) begin
        if (lead == 3'd1) begin
          push = 1'b1;
          job  = rev_job;
        end else begin
          pend_nxt[0] = in_byte;
          pcnt_nxt    = 2'd1;
          slen_nxt    = lead;
        end
      end else begin
        for (int j = 0; j < 3; j++) begin
          if (pcnt_r == 2'(j)) begin
            pend_nxt[j] = in_byte;
          end
        end
        pcnt_nxt = cnt_inc[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= 2'd0;
      slen_r <= 3'd0;
    end else begin
      pcnt_r <= pcnt_nxt;
      slen_r <= slen_nxt;
    end
  end

  // Hold pending bytes
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pend_r[j] <= pend_nxt[j];
    end
  end

endmodule

FILE: design/cp1251u8_back.sv
// Back part: walks queued jobs and sends one result byte per beat.
// Depends on cp1251u8_pkg and assert_macros.svh; pops cp1251u8_queue.
`include "assert_macros.svh"

module cp1251u8_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cp1251u8_pkg::job_t  q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_end
);

  logic                      busy_r, busy_nxt;
  cp1251u8_pkg::job_kind_t   kind_r, kind_nxt;
  logic [3:0][7:0]           buf_r, buf_nxt;
  logic [2:0]                rem_r, rem_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic                      out_run_end_r, out_run_end_nxt;

  logic        slot_free, emit, last;
  logic [2:0]  lead, consume, rem_after;
  logic        complete;
  logic [15:0] cp;
  logic [7:0]  res;

  // cp1251 byte for a code point, question mark when none exists
  function automatic logic [7:0] byte_of_cp(input logic [15:0] c);
    logic [7:0] r;
    r = cp1251u8_pkg::QMARK;
    if (c < 16'h0080) begin
      r = c[7:0];
    end else if (c >= cp1251u8_pkg::CYR_FIRST && c <= cp1251u8_pkg::CYR_LAST) begin
      r = 8'hC0 + 8'(c - cp1251u8_pkg::CYR_FIRST);
    end else begin
      for (int j = 0; j < 64; j++) begin
        if (cp1251u8_pkg::HIGH_MAP[j] == c) begin
          r = 8'h80 | 8'(j);
        end
      end
    end
    return r;
  endfunction

  // Code point of a whole UTF-8 sequence; U+FFFD for a four-byte one
  function automatic logic [15:0] decode_seq(input logic [2:0] len, input logic [7:0] b0,
                                             input logic [7:0] b1, input logic [7:0] b2);
    logic [15:0] r;
    case (len)
      3'd2:    r = {5'd0, b0[4:0], b1[5:0]};
      3'd3:    r = {b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    r = cp1251u8_pkg::REPLACEMENT;
      default: r = {8'h00, b0};
    endcase
    return r;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = busy_r && slot_free;

  // Decode the head of the buffer; a lead byte short of its tail stands alone
  always_comb begin
    lead     = cp1251u8_pkg::lead_len(buf_r[0]);
    complete = (lead > 3'd1) && (lead <= rem_r);
    if (kind_r == cp1251u8_pkg::JOB_FWD) begin
      cp      = {8'h00, buf_r[0]};
      res     = buf_r[0];
      consume = 3'd1;
    end else if (complete) begin
      cp      = decode_seq(lead, buf_r[0], buf_r[1], buf_r[2]);
      res     = byte_of_cp(cp);
      consume = lead;
    end else begin
      cp      = {8'h00, buf_r[0]};
      res     = byte_of_cp(cp);
      consume = 3'd1;
    end
    rem_after = rem_r - consume;
    last      = (rem_after == 3'd0);
  end

  assign q_pop = q_valid && (!busy_r || (emit && last));

  // Load the next job, or shift out what was consumed
  always_comb begin
    busy_nxt = busy_r;
    kind_nxt = kind_r;
    buf_nxt  = buf_r;
    rem_nxt  = rem_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      kind_nxt = q_job.kind;
      buf_nxt  = q_job.bytes;
      rem_nxt  = q_job.cnt;
    end else if (emit) begin
      busy_nxt = !last;
      rem_nxt  = rem_after;
      case (consume)
        3'd1:    buf_nxt = {8'h00, buf_r[3:1]};
        3'd2:    buf_nxt = {16'h0000, buf_r[3:2]};
        3'd3:    buf_nxt = {24'h000000, buf_r[3]};
        default: buf_nxt = '0;
      endcase
    end
  end

  // Fill the output register when it is empty or being taken
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ready;
    out_byte_nxt    = out_byte_r;
    out_run_end_nxt = out_run_end_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_byte_nxt    = res;
      out_run_end_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    buf_r         <= buf_nxt;
    rem_r         <= rem_nxt;
    out_byte_r    <= out_byte_nxt;
    out_run_end_r <= out_run_end_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = out_run_end_r;

  `CP_ASSERT_NEVER(a_busy_empty, clk, rst_n, busy_r && rem_r == 3'd0, "job active with no bytes left")
  `CP_ASSERT_NEVER(a_fwd_len, clk, rst_n, busy_r && kind_r == cp1251u8_pkg::JOB_FWD && rem_r > 3'd3, "forward job longer than three bytes")
  `CP_ASSERT(a_idle_after_end, clk, rst_n, (emit && last && !q_pop) |=> !busy_r, "back part still busy after the closing beat")

endmodule

FILE: bench/tb_cp1251_utf8_transcoder.sv
// Self-checking bench for cp1251_utf8_transcoder: random and directed byte streams in both
// directions, with results predicted by a scoreboard class held in this file.
// Depends on cp1251u8_pkg and the transcoder RTL only.
module tb_cp1251_utf8_transcoder;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam logic [cp1251u8_pkg::ADDR_W-1:0] DIR_ADDR = {cp1251u8_pkg::REG_DIRECTION, 2'b00};

  typedef logic [7:0] octet_q_t [$];

  // Track the transcoder state and the converted bytes still due on the output
  class transcode_tracker;
    logic        dir = cp1251u8_pkg::DIR_TO_UTF8;
    logic [7:0]  held [3];
    int unsigned held_cnt = 0;
    int unsigned seq_len = 0;
    logic [8:0]  due [$];
    int unsigned errors = 0;

    function logic [15:0] code_of(logic [7:0] b);
      if (b < 8'h80) return {8'h00, b};
      if (b >= 8'hC0) return cp1251u8_pkg::CYR_FIRST + 16'(b - 8'hC0);
      return cp1251u8_pkg::HIGH_MAP[b[5:0]];
    endfunction

    function logic [7:0] byte_for_code(logic [15:0] cp);
      if (cp < 16'h0080) return cp[7:0];
      if (cp >= cp1251u8_pkg::CYR_FIRST && cp <= cp1251u8_pkg::CYR_LAST) begin
        return 8'hC0 + 8'(cp - cp1251u8_pkg::CYR_FIRST);
      end
      for (int j = 0; j < 64; j++) begin
        if (cp1251u8_pkg::HIGH_MAP[j] == cp) return 8'h80 + 8'(j);
      end
      return cp1251u8_pkg::QMARK;
    endfunction

    function int unsigned seq_len_of(logic [7:0] c);
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 1;
    endfunction

    function octet_q_t utf8_of(logic [15:0] cp);
      octet_q_t q;
      if (cp == 16'h0000) return q;
      if (cp < 16'h0080) begin
        q.insert(q.size(), cp[7:0]);
      end else if (cp < cp1251u8_pkg::TWO_BYTE_LIMIT) begin
        q.insert(q.size(), {3'b110, cp[10:6]});
        q.insert(q.size(), {2'b10, cp[5:0]});
      end else begin
        q.insert(q.size(), {4'b1110, cp[15:12]});
        q.insert(q.size(), {2'b10, cp[11:6]});
        q.insert(q.size(), {2'b10, cp[5:0]});
      end
      return q;
    endfunction

    // Work out the bytes one accepted source beat produces
    function void note_source_byte(logic [7:0] b, logic fin);
      logic [7:0]  chunk [4];
      logic [7:0]  found [$];
      logic [15:0] cp;
      int unsigned n, i, len;
      bit          flush;
      flush = 0;
      if (dir == cp1251u8_pkg::DIR_TO_UTF8) begin
        held_cnt = 0;
        seq_len = 0;
        found = utf8_of(code_of(b));
      end else if (fin || held_cnt == 0) begin
        if (fin) begin
          flush = 1;
        end else begin
          len = seq_len_of(b);
          if (len == 1) begin
            found.insert(found.size(), byte_for_code({8'h00, b}));
          end else begin
            held[0] = b;
            held_cnt = 1;
            seq_len = len;
          end
        end
      end else if (held_cnt + 1 < seq_len) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        flush = 1;
      end
      // Reparse held bytes plus this one; a short lead byte stands alone
      if (flush) begin
        n = held_cnt;
        for (i = 0; i < n; i++) chunk[i] = held[i];
        chunk[n] = b;
        n++;
        i = 0;
        while (i < n && found.size() < 3) begin
          len = seq_len_of(chunk[i]);
          if (len > 1 && i + len <= n) begin
            case (len)
              2: cp = {5'b0, chunk[i][4:0], chunk[i+1][5:0]};
              3: cp = {chunk[i][3:0], chunk[i+1][5:0], chunk[i+2][5:0]};
              default: cp = cp1251u8_pkg::REPLACEMENT;
            endcase
            i += len;
          end else begin
            cp = {8'h00, chunk[i]};
            i++;
          end
          found.insert(found.size(), byte_for_code(cp));
        end
        held_cnt = 0;
        seq_len = 0;
      end
      foreach (found[k]) due.insert(due.size(), {k == found.size() - 1, found[k]});
    endfunction

    function void check_converted_byte(logic [7:0] b, logic last);
      logic [8:0] want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %h run_end %b", $time, b, last);
        return;
      end
      want = due.pop_front();
      if (b !== want[7:0]) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, want[7:0], b);
      end
      if (last !== want[8]) begin
        errors++;
        $display("%0t: out_run_end expected %b actual %b", $time, want[8], last);
      end
    endfunction

    function int unsigned outstanding();
      return due.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [7:0]                        in_byte;
  logic                              in_final_byte;
  logic                              out_valid;
  logic                              out_ready;
  logic [7:0]                        out_byte;
  logic                              out_run_end;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [cp1251u8_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [31:0]                       cfg_pwdata;
  logic [31:0]                       cfg_prdata;
  logic                              cfg_pready;

  transcode_tracker sb;
  bit               quiet;
  bit               hold_req;
  int unsigned      bytes_sent;

  cp1251_utf8_transcoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("FAIL cp1251_utf8_transcoder");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_converted_byte(out_byte, out_run_end);
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // Offer one source beat and hold it until accepted; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    in_final_byte = fin;
    do @(posedge clk); while (!in_ready);
    sb.note_source_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every due byte is out and the block has settled
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the direction register once idle, then read it back
  task automatic set_direction(input logic v);
    wait_drained();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = DIR_ADDR;
    cfg_pwdata = {31'b0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.dir = v;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== v) begin
      sb.errors++;
      $display("%0t: direction readback expected %b actual %b", $time, v, cfg_prdata[0]);
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic offer_cp1251(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Mostly well-formed UTF-8 runs, some truncated, some noise bytes
  task automatic offer_utf8(input int unsigned count);
    octet_q_t    run;
    int unsigned start, kind, len, cut;
    logic        fin;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      run.delete();
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        run = sb.utf8_of(sb.code_of(8'($urandom)));
        if (run.size() == 0) run.insert(0, 8'h00);
      end else if (kind < 15 || kind >= 17) begin
        len = (kind < 11) ? 2 : (kind < 13) ? 3 : (kind < 15) ? 4 : $urandom_range(2, 4);
        case (len)
          2: run.insert(run.size(), {3'b110, 5'($urandom)});
          3: run.insert(run.size(), {4'b1110, 4'($urandom)});
          default: run.insert(run.size(), {5'b11110, 3'($urandom)});
        endcase
        repeat (len - 1) run.insert(run.size(), {2'b10, 6'($urandom)});
        if (kind >= 17) begin
          cut = $urandom_range(1, len - 1);
          while (run.size() > cut) run.delete(run.size() - 1);
        end
      end else begin
        run.insert(run.size(), 8'($urandom));
      end
      foreach (run[k]) begin
        if (kind >= 17 && k == run.size() - 1) fin = $urandom_range(0, 1);
        else fin = ($urandom_range(0, 11) == 0);
        push_byte(run[k], fin);
      end
    end
  endtask

  initial begin
    logic [8:0] fwd_list [7];
    logic [8:0] rev_list [18];
    // {final_byte, byte}: NUL, ASCII, table bytes, the undefined byte, Cyrillic ends
    fwd_list = '{9'h000, 9'h17F, 9'h080, 9'h198, 9'h0B9, 9'h0C0, 9'h0FF};
    // Overlong NUL, Cyrillic, numero sign, four-byte, lone table byte, flushed leftovers
    rev_list = '{9'h0C0, 9'h080, 9'h0D0, 9'h090, 9'h0E2, 9'h084, 9'h096,
                 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0A0, 9'h0F0, 9'h09F,
                 9'h141, 9'h1D0, 9'h0E2, 9'h180};
    sb = new;
    quiet = 0;
    hold_req = 0;
    bytes_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_final_byte = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    set_direction(cp1251u8_pkg::DIR_TO_UTF8);
    foreach (fwd_list[k]) push_byte(fwd_list[k][7:0], fwd_list[k][8]);
    set_direction(cp1251u8_pkg::DIR_TO_CP1251);
    foreach (rev_list[k]) push_byte(rev_list[k][7:0], rev_list[k][8]);

    offer_utf8(110);
    // Pause the source mid-stream until all output is out
    set_direction(cp1251u8_pkg::DIR_TO_UTF8);
    offer_cp1251(35);
    wait_drained();
    offer_cp1251(35);
    // Hold the output off while the source keeps pushing back to back
    set_direction(cp1251u8_pkg::DIR_TO_CP1251);
    quiet = 1;
    hold_req = 1;
    offer_utf8(100);
    quiet = 0;
    set_direction(cp1251u8_pkg::DIR_TO_UTF8);
    offer_cp1251(40);
    set_direction(cp1251u8_pkg::DIR_TO_CP1251);
    offer_utf8(65);

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS cp1251_utf8_transcoder");
    end else begin
      $display("FAIL cp1251_utf8_transcoder");
    end
    $finish;
  end
endmodule
